[src/pfp_pkg.sv]
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants for the particle sensor frame parser.
// ----------------------------------------------------------------------------
package pfp_pkg;

    localparam int MAX_FRAME    = 64;
    localparam int MIN_FRAME    = 30;
    localparam int NUM_READINGS = 12;

    localparam int LEN_W  = 7;
    localparam int POS_W  = 6;
    localparam int IDX_W  = 4;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [7:0]       START_CHAR         = 8'h42;
    localparam logic [LEN_W-1:0] LEN_RESET          = 7'd32;
    localparam logic [LEN_W-1:0] LEN_MIN            = LEN_W'(MIN_FRAME);
    localparam logic [LEN_W-1:0] LEN_MAX            = LEN_W'(MAX_FRAME);
    localparam logic [POS_W-1:0] FIRST_READING_BYTE = 6'd4;
    localparam logic [POS_W-1:0] LAST_READING_BYTE  = 6'd27;
    localparam logic [IDX_W-1:0] LAST_IDX           = IDX_W'(NUM_READINGS - 1);

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_START = 2'd1,
        ST_BAD_SUM  = 2'd2
    } pfp_status_t;

    typedef enum logic {
        S_RECV = 1'b0,
        S_EMIT = 1'b1
    } pfp_state_t;

    typedef struct packed {
        logic take_byte;
        logic next_result;
    } pfp_cmd_t;

    typedef struct packed {
        logic final_byte;
        logic last_result;
    } pfp_stat_t;

endpackage

[src/pfp_if.sv]
// ----------------------------------------------------------------------------
// pfp_byte_if / pfp_result_if
// Valid/ready channels carrying received bytes and parser results.
// ----------------------------------------------------------------------------
interface pfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  reading_index;
    logic [15:0] reading_value;
    logic        last;

    modport source (output valid, output status, output reading_index,
                    output reading_value, output last, input ready);
    modport sink   (input valid, input status, input reading_index,
                    input reading_value, input last, output ready);
endinterface

[src/particle_frame_parser_unit.sv]
// ----------------------------------------------------------------------------
// particle_frame_parser_unit
// Frames received bytes, checks start character and checksum, emits readings.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  in_ch     in   valid/ready    rx_byte[7:0]
//  out_ch    out  valid/ready    status[1:0] reading_index[3:0]
//                                reading_value[15:0] last
//  apb       in   psel/penable   paddr[2:0] pwdata/prdata[31:0], frame_length
//
//  Each handshake takes a byte. The final byte of a frame starts the result
//  sequencer: one error result, or twelve readings at one per cycle, read
//  from the reading store by the result counter. Input is held off until the
//  last result transfers. Output stalls simply hold the current result.
//  After reset frame_length is 32 and the parser waits for byte 0.
// ----------------------------------------------------------------------------
module particle_frame_parser_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pfp_pkg::ADDR_W-1:0]   paddr,
    input  logic [pfp_pkg::DATA_W-1:0]   pwdata,
    output logic [pfp_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    pfp_byte_if.sink                     in_ch,
    pfp_result_if.source                 out_ch
);

    logic [pfp_pkg::LEN_W-1:0] frame_length_reg, frame_length_next;
    pfp_pkg::pfp_cmd_t         cmd;
    pfp_pkg::pfp_stat_t        stat;
    logic                      reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == pfp_pkg::REG_FRAME_LENGTH);

    always_comb
    begin
        frame_length_next = frame_length_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            frame_length_next = pwdata[pfp_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_length_reg <= pfp_pkg::LEN_RESET;
        end
        else
        begin
            frame_length_reg <= frame_length_next;
        end
    end

    assign prdata = reg_hit ? {{(pfp_pkg::DATA_W - pfp_pkg::LEN_W){1'b0}}, frame_length_reg}
                            : '0;

    pfp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pfp_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_length  (frame_length_reg),
        .rx_byte       (in_ch.rx_byte),
        .cmd           (cmd),
        .stat          (stat),
        .status        (out_ch.status),
        .reading_index (out_ch.reading_index),
        .reading_value (out_ch.reading_value),
        .last          (out_ch.last)
    );

endmodule

[src/pfp_ctrl.sv]
// ----------------------------------------------------------------------------
// pfp_ctrl
// Controller: receives bytes until a frame ends, then walks the results out.
// ----------------------------------------------------------------------------
module pfp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  pfp_pkg::pfp_stat_t stat,
    output pfp_pkg::pfp_cmd_t  cmd
);

    pfp_pkg::pfp_state_t state_reg;
    pfp_pkg::pfp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfp_pkg::S_RECV;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pfp_pkg::S_RECV:
            begin
                if (in_valid && stat.final_byte)
                begin
                    state_next = pfp_pkg::S_EMIT;
                end
            end
            pfp_pkg::S_EMIT:
            begin
                if (out_ready && stat.last_result)
                begin
                    state_next = pfp_pkg::S_RECV;
                end
            end
            default:
            begin
                state_next = pfp_pkg::S_RECV;
            end
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        out_valid       = 1'b0;
        cmd.take_byte   = 1'b0;
        cmd.next_result = 1'b0;
        case (state_reg)
            pfp_pkg::S_RECV:
            begin
                in_ready      = 1'b1;
                cmd.take_byte = in_valid;
            end
            pfp_pkg::S_EMIT:
            begin
                out_valid       = 1'b1;
                cmd.next_result = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/pfp_datapath.sv]
// ----------------------------------------------------------------------------
// pfp_datapath
// Byte position, running sum, start/checksum capture and the reading store.
// ----------------------------------------------------------------------------
module pfp_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pfp_pkg::LEN_W-1:0]   frame_length,
    input  logic [7:0]                  rx_byte,
    input  pfp_pkg::pfp_cmd_t           cmd,
    output pfp_pkg::pfp_stat_t          stat,
    output logic [1:0]                  status,
    output logic [pfp_pkg::IDX_W-1:0]   reading_index,
    output logic [15:0]                 reading_value,
    output logic                        last
);

    logic [pfp_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]               sum_reg, sum_next;
    logic                      start_ok_reg, start_ok_next;
    logic [7:0]                pend_reg, pend_next;
    logic [7:0]                cs_hi_reg, cs_hi_next;
    pfp_pkg::pfp_status_t      status_reg, status_next;
    logic [pfp_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [15:0]               store [pfp_pkg::NUM_READINGS];
    logic [15:0]               value_reg;

    logic [pfp_pkg::LEN_W-1:0] len;
    logic [pfp_pkg::LEN_W-1:0] pos_ext;
    logic                      first_byte;
    logic                      sum_byte;
    logic                      cs_hi_byte;
    logic                      in_readings;
    logic [pfp_pkg::POS_W-1:0] rel;
    logic                      wr_store;
    logic [pfp_pkg::IDX_W-1:0] wr_idx;
    logic [15:0]               sum_base;
    logic [15:0]               received;

    always_comb
    begin
        if (frame_length < pfp_pkg::LEN_MIN)
        begin
            len = pfp_pkg::LEN_MIN;
        end
        else if (frame_length > pfp_pkg::LEN_MAX)
        begin
            len = pfp_pkg::LEN_MAX;
        end
        else
        begin
            len = frame_length;
        end
    end

    assign pos_ext         = {1'b0, pos_reg};
    assign first_byte      = (pos_reg == '0);
    assign stat.final_byte = (pos_ext + 7'd1) >= len;
    assign sum_byte        = (pos_ext + 7'd2) < len;
    assign cs_hi_byte      = (pos_ext + 7'd2) == len;
    assign in_readings     = (pos_reg >= pfp_pkg::FIRST_READING_BYTE) &&
                             (pos_reg <= pfp_pkg::LAST_READING_BYTE);
    assign rel             = pos_reg - pfp_pkg::FIRST_READING_BYTE;
    assign wr_idx          = rel[pfp_pkg::IDX_W:1];
    assign wr_store        = cmd.take_byte && in_readings && rel[0];
    assign sum_base        = first_byte ? 16'd0 : sum_reg;
    assign received        = {cs_hi_reg, rx_byte};

    always_comb
    begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        start_ok_next = start_ok_reg;
        pend_next     = pend_reg;
        cs_hi_next    = cs_hi_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;

        if (cmd.take_byte)
        begin
            if (first_byte)
            begin
                start_ok_next = (rx_byte == pfp_pkg::START_CHAR);
            end
            sum_next = sum_byte ? (sum_base + {8'd0, rx_byte}) : sum_base;
            if (in_readings && !rel[0])
            begin
                pend_next = rx_byte;
            end
            if (stat.final_byte)
            begin
                pos_next = '0;
                idx_next = '0;
                if (!start_ok_next)
                begin
                    status_next = pfp_pkg::ST_NO_START;
                end
                else if (received != sum_next)
                begin
                    status_next = pfp_pkg::ST_BAD_SUM;
                end
                else
                begin
                    status_next = pfp_pkg::ST_OK;
                end
            end
            else
            begin
                pos_next = pos_reg + 6'd1;
                if (cs_hi_byte)
                begin
                    cs_hi_next = rx_byte;
                end
            end
        end
        else if (cmd.next_result)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            start_ok_reg <= 1'b0;
            pend_reg     <= '0;
            cs_hi_reg    <= '0;
            status_reg   <= pfp_pkg::ST_OK;
            idx_reg      <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            start_ok_reg <= start_ok_next;
            pend_reg     <= pend_next;
            cs_hi_reg    <= cs_hi_next;
            status_reg   <= status_next;
            idx_reg      <= idx_next;
        end
    end

    // read data follows the result counter's next value, so it lines up with idx_reg
    always_ff @(posedge clk)
    begin
        if (wr_store)
        begin
            store[wr_idx] <= {pend_reg, rx_byte};
        end
        value_reg <= store[idx_next];
    end

    // error results carry index 0, value 0 and end the frame
    assign stat.last_result = (status_reg != pfp_pkg::ST_OK) ||
                              (idx_reg == pfp_pkg::LAST_IDX);
    assign status        = status_reg;
    assign reading_index = (status_reg == pfp_pkg::ST_OK) ? idx_reg : '0;
    assign reading_value = (status_reg == pfp_pkg::ST_OK) ? value_reg : 16'd0;
    assign last          = stat.last_result;

endmodule
